// ===== rtl/ppsc_pkg.sv =====
// Package for the pressure loop speed controller.
// Holds field widths, mode codes, register indexes and reset values; no dependencies.
package ppsc_pkg;

   localparam int PRESS_W         = 16;
   localparam int ERR_W           = PRESS_W + 1;
   localparam int SPEED_W         = 24;
   localparam int SPEED_FRAC_BITS = 8;
   localparam int RPM_W           = SPEED_W - SPEED_FRAC_BITS;
   localparam int GAIN_W          = 32;
   localparam int BAND_W          = 16;
   localparam int MODE_W          = 2;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 32;

   localparam int MULB_W    = ERR_W + 2;
   localparam int PROD_W    = GAIN_W + MULB_W;
   localparam int ACC_W     = PROD_W + 1;
   localparam int RND_SHIFT = 16 - SPEED_FRAC_BITS;
   localparam int DELTA_W   = ACC_W - RND_SHIFT;
   localparam int SUM_W     = DELTA_W + 2;

   localparam int DIVD_W    = SPEED_W + PRESS_W;
   localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

   localparam logic [ACC_W-1:0] RND_POS = ACC_W'(1 << (RND_SHIFT - 1));
   localparam logic [ACC_W-1:0] RND_NEG = ACC_W'((1 << (RND_SHIFT - 1)) - 1);

   localparam logic [MODE_W-1:0] MODE_PRESSURIZE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HOLD       = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_HOLD  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_BAND = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd6;

   localparam logic [BAND_W-1:0]  HOLD_BAND_RST = 16'd100;
   localparam logic [SPEED_W-1:0] THRESHOLD_RST = 24'd1280;

endpackage

// ===== rtl/ppsc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the hold-mode speed limit.
// Depends on ppsc_pkg for the operand widths.
module ppsc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ppsc_pkg::DIVD_W-1:0]   dividend,
   input  logic [ppsc_pkg::BAND_W-1:0]   divisor,
   output logic                          done,
   output logic [ppsc_pkg::DIVD_W-1:0]   quotient
);
   import ppsc_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [BAND_W-1:0]    rem_ff, rem_in;
   logic [BAND_W-1:0]    dvs_ff, dvs_in;
   logic [DIVD_W-1:0]    quo_ff, quo_in;
   logic [BAND_W:0]      shifted;
   logic [BAND_W:0]      trial;

   assign shifted = {rem_ff, quo_ff[DIVD_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVD_W);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (!trial[BAND_W]) begin
            rem_in = trial[BAND_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[BAND_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/pressure_pid_speed_controller_top.sv =====
// Pressure loop speed controller: incremental PID with anti-windup on one shared multiplier.
// A request runs the multiply, limit, rounding, sum, clamp and dispatch steps before rsp_valid;
// hold mode adds the limit multiply and the 40-step divider, and other modes go straight to dispatch.
// One transaction at a time: no new request is taken until its result is dispatched; a result
// that is not taken holds the sequencer in its dispatch step and stalls the input.
// Reset is synchronous and active high; it clears the PID state and loads register defaults.
module pressure_pid_speed_controller_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ppsc_pkg::MODE_W-1:0]        req_mode,
   input  logic [ppsc_pkg::PRESS_W-1:0]       req_target_pressure,
   input  logic [ppsc_pkg::PRESS_W-1:0]       req_measured_pressure,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ppsc_pkg::SPEED_W-1:0]       rsp_speed_out,
   output logic                               rsp_send_speed,
   output logic [ppsc_pkg::RPM_W-1:0]         rsp_target_rpm,
   output logic                               rsp_slow_period,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ppsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ppsc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ppsc_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MP    = 4'd1;
   localparam logic [3:0] S_MI    = 4'd2;
   localparam logic [3:0] S_MD    = 4'd3;
   localparam logic [3:0] S_MA    = 4'd4;
   localparam logic [3:0] S_ML    = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_DWAIT = 4'd7;
   localparam logic [3:0] S_LIM   = 4'd8;
   localparam logic [3:0] S_RND   = 4'd9;
   localparam logic [3:0] S_SUM   = 4'd10;
   localparam logic [3:0] S_CLMP  = 4'd11;
   localparam logic [3:0] S_SEND  = 4'd12;

   logic [3:0]                state_ff, state_in;
   logic signed [GAIN_W-1:0]  gain_p_ff, gain_p_in;
   logic signed [GAIN_W-1:0]  gain_i_ff, gain_i_in;
   logic signed [GAIN_W-1:0]  gain_d_ff, gain_d_in;
   logic [SPEED_W-1:0]        max_speed_ff, max_speed_in;
   logic [SPEED_W-1:0]        min_hold_ff, min_hold_in;
   logic [BAND_W-1:0]         band_ff, band_in;
   logic [SPEED_W-1:0]        thresh_ff, thresh_in;

   logic [MODE_W-1:0]         mode_ff, mode_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [ERR_W-1:0]   err_back1_ff, err_back1_in;
   logic signed [ERR_W-1:0]   err_back2_ff, err_back2_in;
   logic [SPEED_W-1:0]        pid_ff, pid_in;
   logic [SPEED_W-1:0]        last_sent_ff, last_sent_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [SPEED_W-1:0]        lim_ff, lim_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [SPEED_W-1:0]        speed_ff, speed_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SPEED_W-1:0]        rsp_speed_ff, rsp_speed_in;
   logic                      rsp_send_ff, rsp_send_in;
   logic [RPM_W-1:0]          rsp_rpm_ff, rsp_rpm_in;
   logic                      rsp_slow_ff, rsp_slow_in;

   logic signed [ERR_W-1:0]   err_new;
   logic signed [MULB_W-1:0]  err_x, last_x, prev_x, diff1, diff2;
   logic signed [GAIN_W-1:0]  mul_a;
   logic signed [MULB_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [ACC_W-1:0]   rnd_sum;
   logic signed [SUM_W-1:0]   sum_val, lim_s, pid_s;
   logic                      drop;
   logic [BAND_W-1:0]         band_eff;
   logic                      div_start, div_done;
   logic [DIVD_W-1:0]         div_quot;
   logic [SPEED_W-1:0]        lim_raw;
   logic [SPEED_W-1:0]        speed_diff, sent_sel;
   logic                      send;
   logic [ERR_W-1:0]          err_abs;
   logic [ERR_W+3:0]          err_x10, band_x3;
   logic                      slow;
   logic                      out_free;

   assign err_new  = $signed({1'b0, req_target_pressure}) - $signed({1'b0, req_measured_pressure});
   assign err_x    = MULB_W'(err_ff);
   assign last_x   = MULB_W'(err_back1_ff);
   assign prev_x   = MULB_W'(err_back2_ff);
   assign diff1    = err_x - last_x;
   assign diff2    = err_x - (last_x <<< 1) + prev_x;
   assign band_eff = (band_ff == '0) ? BAND_W'(1) : band_ff;

   always_comb begin
      case (state_ff)
         S_MP: begin
            mul_a = gain_p_ff;
            mul_b = diff1;
         end
         S_MI: begin
            mul_a = gain_i_ff;
            mul_b = err_x;
         end
         S_MD: begin
            mul_a = gain_d_ff;
            mul_b = diff2;
         end
         default: begin
            mul_a = $signed({{(GAIN_W-SPEED_W){1'b0}}, max_speed_ff});
            mul_b = err_x;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign rnd_sum = acc_ff + $signed(acc_ff[ACC_W-1] ? RND_NEG : RND_POS);
   assign lim_s   = $signed({{(SUM_W-SPEED_W){1'b0}}, lim_ff});
   assign pid_s   = $signed({{(SUM_W-SPEED_W){1'b0}}, pid_ff});
   assign sum_val = SUM_W'(delta_ff) + pid_s;
   assign drop    = (sum_val > lim_s && delta_ff > 0) || (sum_val < 0 && delta_ff < 0);

   assign lim_raw = (err_ff > 0) ?
                    ((|div_quot[DIVD_W-1:SPEED_W]) ? {SPEED_W{1'b1}} : div_quot[SPEED_W-1:0]) :
                    '0;

   assign speed_diff = (speed_ff >= last_sent_ff) ? speed_ff - last_sent_ff
                                                  : last_sent_ff - speed_ff;
   assign send       = speed_diff > thresh_ff;
   assign sent_sel   = send ? speed_ff : last_sent_ff;
   assign err_abs    = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
   assign err_x10    = ({4'b0, err_abs} << 3) + ({4'b0, err_abs} << 1);
   assign band_x3    = (ERR_W+4)'({band_eff, 1'b0}) + (ERR_W+4)'(band_eff);
   assign slow       = (mode_ff == MODE_HOLD) && (err_x10 < band_x3);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign div_start = (state_ff == S_DIV);

   ppsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff[DIVD_W-1:0]),
      .divisor  (band_eff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      gain_p_in    = gain_p_ff;
      gain_i_in    = gain_i_ff;
      gain_d_in    = gain_d_ff;
      max_speed_in = max_speed_ff;
      min_hold_in  = min_hold_ff;
      band_in      = band_ff;
      thresh_in    = thresh_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_P:    gain_p_in    = $signed(csr_wdata);
            CSR_GAIN_I:    gain_i_in    = $signed(csr_wdata);
            CSR_GAIN_D:    gain_d_in    = $signed(csr_wdata);
            CSR_MAX_SPEED: max_speed_in = csr_wdata[SPEED_W-1:0];
            CSR_MIN_HOLD:  min_hold_in  = csr_wdata[SPEED_W-1:0];
            CSR_HOLD_BAND: band_in      = csr_wdata[BAND_W-1:0];
            CSR_THRESHOLD: thresh_in    = csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      err_in       = err_ff;
      err_back1_in = err_back1_ff;
      err_back2_in = err_back2_ff;
      pid_in       = pid_ff;
      last_sent_in = last_sent_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      lim_in       = lim_ff;
      delta_in     = delta_ff;
      sum_in       = sum_ff;
      speed_in     = speed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_speed_in = rsp_speed_ff;
      rsp_send_in  = rsp_send_ff;
      rsp_rpm_in   = rsp_rpm_ff;
      rsp_slow_in  = rsp_slow_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in = req_mode;
               err_in  = err_new;
               if (req_mode == MODE_PRESSURIZE || req_mode == MODE_HOLD) begin
                  state_in = S_MP;
               end else begin
                  err_back1_in = '0;
                  err_back2_in = '0;
                  pid_in       = '0;
                  speed_in     = '0;
                  state_in     = S_SEND;
               end
            end
         end
         S_MP: begin
            prod_in  = mul_p;
            state_in = S_MI;
         end
         S_MI: begin
            acc_in   = ACC_W'(prod_ff);
            prod_in  = mul_p;
            state_in = S_MD;
         end
         S_MD: begin
            acc_in   = acc_ff + ACC_W'(prod_ff);
            prod_in  = mul_p;
            state_in = S_MA;
         end
         S_MA: begin
            acc_in   = acc_ff + ACC_W'(prod_ff);
            state_in = (mode_ff == MODE_HOLD) ? S_ML : S_LIM;
         end
         S_ML: begin
            prod_in  = mul_p;
            state_in = S_DIV;
         end
         S_DIV: begin
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_done) begin
               state_in = S_LIM;
            end
         end
         S_LIM: begin
            if (mode_ff == MODE_HOLD) begin
               lim_in = (lim_raw < min_hold_ff) ? min_hold_ff : lim_raw;
            end else begin
               lim_in = max_speed_ff;
            end
            state_in = S_RND;
         end
         S_RND: begin
            delta_in = rnd_sum[ACC_W-1:RND_SHIFT];
            state_in = S_SUM;
         end
         S_SUM: begin
            sum_in   = drop ? pid_s : sum_val;
            state_in = S_CLMP;
         end
         S_CLMP: begin
            if (sum_ff > lim_s) begin
               speed_in = lim_ff;
            end else if (sum_ff < 0) begin
               speed_in = '0;
            end else begin
               speed_in = sum_ff[SPEED_W-1:0];
            end
            pid_in       = speed_in;
            err_back2_in = err_back1_ff;
            err_back1_in = err_ff;
            state_in     = S_SEND;
         end
         S_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = speed_ff;
               rsp_send_in  = send;
               rsp_rpm_in   = sent_sel[SPEED_W-1:SPEED_FRAC_BITS];
               rsp_slow_in  = slow;
               last_sent_in = sent_sel;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         max_speed_ff <= '0;
         min_hold_ff  <= '0;
         band_ff      <= HOLD_BAND_RST;
         thresh_ff    <= THRESHOLD_RST;
         err_back1_ff <= '0;
         err_back2_ff <= '0;
         pid_ff       <= '0;
         last_sent_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         max_speed_ff <= max_speed_in;
         min_hold_ff  <= min_hold_in;
         band_ff      <= band_in;
         thresh_ff    <= thresh_in;
         err_back1_ff <= err_back1_in;
         err_back2_ff <= err_back2_in;
         pid_ff       <= pid_in;
         last_sent_ff <= last_sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      err_ff       <= err_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      lim_ff       <= lim_in;
      delta_ff     <= delta_in;
      sum_ff       <= sum_in;
      speed_ff     <= speed_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_send_ff  <= rsp_send_in;
      rsp_rpm_ff   <= rsp_rpm_in;
      rsp_slow_ff  <= rsp_slow_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_speed_out   = rsp_speed_ff;
   assign rsp_send_speed  = rsp_send_ff;
   assign rsp_target_rpm  = rsp_rpm_ff;
   assign rsp_slow_period = rsp_slow_ff;

   // A new result is only ever loaded from the dispatch step.
   a_rsp_from_send: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_SEND)
      else $error("result appeared outside the dispatch step");

   // A dispatched speed and the reported integer rpm agree.
   a_rpm_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_speed |->
         rsp_target_rpm == rsp_speed_out[SPEED_W-1:SPEED_FRAC_BITS])
      else $error("target rpm does not match dispatched speed");

   // The divider finishes only while the sequencer waits for it.
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DWAIT)
      else $error("divider finished outside its wait step");

   // The PID output never exceeds the limit it was clamped against.
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLMP |=> pid_ff <= lim_ff)
      else $error("PID output above its limit");

endmodule

// ===== tb/tb_pressure_pid_speed_controller_top.sv =====
// Self-checking testbench for pressure_pid_speed_controller_top: a directed table, then random ticks.
// Each result is scored against its typed row or an in-bench model of the incremental PID loop.
// Depends on ppsc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_pressure_pid_speed_controller_top;
   import ppsc_pkg::*;

   localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_OTHER   = 2'd3;

   localparam longint SPEED_MAX       = (longint'(1) << SPEED_W) - 1;
   localparam int     DIRECTED_ROWS   = 24;
   localparam int     FIRST_TUNED_ROW = 9;
   localparam int     RANDOM_PHASES   = 8;
   localparam int     ITEMS_PER_PHASE = 170;
   localparam int     STALL_PHASE     = 2;
   localparam int     STALL_CYCLES    = 400;
   localparam int     LATENCY_GUARD   = 64;
   localparam int     CYCLE_LIMIT     = 1000000;

   typedef struct packed {
      logic [SPEED_W-1:0] speed;
      logic               send;
      logic [RPM_W-1:0]   rpm;
      logic               slow;
   } speed_result_type;

   typedef struct packed {
      logic               typed;
      logic [MODE_W-1:0]  mode;
      logic [PRESS_W-1:0] target;
      logic [PRESS_W-1:0] measured;
      speed_result_type   want;
   } directed_row_type;

   localparam speed_result_type QUIET      = '0;
   localparam speed_result_type QUIET_SLOW = '{24'd0, 1'b0, 16'd0, 1'b1};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [MODE_W-1:0]     req_mode;
   logic [PRESS_W-1:0]    req_target_pressure;
   logic [PRESS_W-1:0]    req_measured_pressure;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [SPEED_W-1:0]    rsp_speed_out;
   logic                  rsp_send_speed;
   logic [RPM_W-1:0]      rsp_target_rpm;
   logic                  rsp_slow_period;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   longint cfg_gain_p     = 0;
   longint cfg_gain_i     = 0;
   longint cfg_gain_d     = 0;
   longint cfg_max_speed  = 0;
   longint cfg_min_hold   = 0;
   longint cfg_band       = HOLD_BAND_RST;
   longint cfg_threshold  = THRESHOLD_RST;
   int     err_back1      = 0;
   int     err_back2      = 0;
   longint pid_level      = 0;
   longint last_sent      = 0;

   speed_result_type pending_speed_results[$];
   int               fail_count     = 0;
   int               cycle_count    = 0;
   int               stall_requests = 0;
   bit               no_gaps        = 1'b0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{1'b1, MODE_STOPPED,    16'd0,     16'd0,     QUIET},
      '{1'b1, MODE_PRESSURIZE, 16'd65535, 16'd0,     QUIET},
      '{1'b1, MODE_PRESSURIZE, 16'd0,     16'd65535, QUIET},
      '{1'b1, MODE_HOLD,       16'd65535, 16'd0,     QUIET},
      '{1'b1, MODE_HOLD,       16'd100,   16'd71,    QUIET_SLOW},
      '{1'b1, MODE_HOLD,       16'd100,   16'd70,    QUIET},
      '{1'b1, MODE_HOLD,       16'd0,     16'd29,    QUIET_SLOW},
      '{1'b1, MODE_OTHER,      16'd65535, 16'd65535, QUIET},
      '{1'b1, MODE_HOLD,       16'd65535, 16'd65535, QUIET_SLOW},
      '{1'b0, MODE_PRESSURIZE, 16'd30000, 16'd0,     QUIET},
      '{1'b0, MODE_PRESSURIZE, 16'd30000, 16'd0,     QUIET},
      '{1'b0, MODE_PRESSURIZE, 16'd30000, 16'd10000, QUIET},
      '{1'b0, MODE_PRESSURIZE, 16'd0,     16'd65535, QUIET},
      '{1'b0, MODE_PRESSURIZE, 16'd65535, 16'd0,     QUIET},
      '{1'b0, MODE_PRESSURIZE, 16'd65535, 16'd0,     QUIET},
      '{1'b0, MODE_PRESSURIZE, 16'd65535, 16'd0,     QUIET},
      '{1'b0, MODE_PRESSURIZE, 16'd32768, 16'd32768, QUIET},
      '{1'b0, MODE_HOLD,       16'd1000,  16'd0,     QUIET},
      '{1'b0, MODE_HOLD,       16'd0,     16'd1000,  QUIET},
      '{1'b0, MODE_HOLD,       16'd5,     16'd5,     QUIET},
      '{1'b0, MODE_HOLD,       16'd1,     16'd0,     QUIET},
      '{1'b0, MODE_OTHER,      16'd65535, 16'd0,     QUIET},
      '{1'b0, MODE_PRESSURIZE, 16'd500,   16'd0,     QUIET},
      '{1'b0, MODE_STOPPED,    16'd0,     16'd65535, QUIET}
   };

   pressure_pid_speed_controller_top uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_mode              (req_mode),
      .req_target_pressure   (req_target_pressure),
      .req_measured_pressure (req_measured_pressure),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_speed_out         (rsp_speed_out),
      .rsp_send_speed        (rsp_send_speed),
      .rsp_target_rpm        (rsp_target_rpm),
      .rsp_slow_period       (rsp_slow_period),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic speed_result_type advance_speed_loop(input logic [MODE_W-1:0] mode,
         input logic [PRESS_W-1:0] target, input logic [PRESS_W-1:0] measured);
      speed_result_type r;
      int     e;
      int     ae;
      longint band;
      longint ceiling;
      longint sum;
      longint mag;
      longint incr;
      longint level;
      longint diff;
      e = int'(target) - int'(measured);
      band = (cfg_band == 0) ? 1 : cfg_band;
      ceiling = cfg_max_speed;
      if (mode == MODE_HOLD) begin
         ceiling = 0;
         if (e > 0) begin
            ceiling = cfg_max_speed * e / band;
            if (ceiling > SPEED_MAX) ceiling = SPEED_MAX;
         end
         if (ceiling < cfg_min_hold) ceiling = cfg_min_hold;
      end
      if (mode == MODE_PRESSURIZE || mode == MODE_HOLD) begin
         sum = cfg_gain_p * (e - err_back1) + cfg_gain_i * e
             + cfg_gain_d * (e - 2 * err_back1 + err_back2);
         mag = (sum < 0) ? -sum : sum;
         mag = (mag + (longint'(1) << (RND_SHIFT - 1))) >> RND_SHIFT;
         incr = (sum < 0) ? -mag : mag;
         level = pid_level + incr;
         if ((level > ceiling && incr > 0) || (level < 0 && incr < 0)) incr = 0;
         level = pid_level + incr;
         if (level > ceiling) level = ceiling;
         if (level < 0) level = 0;
         pid_level = level;
         err_back2 = err_back1;
         err_back1 = e;
      end else begin
         pid_level = 0;
         err_back1 = 0;
         err_back2 = 0;
      end
      diff = (pid_level > last_sent) ? pid_level - last_sent : last_sent - pid_level;
      r.send = (diff > cfg_threshold);
      if (r.send) last_sent = pid_level;
      ae = (e < 0) ? -e : e;
      r.speed = pid_level[SPEED_W-1:0];
      r.rpm = RPM_W'(last_sent >> SPEED_FRAC_BITS);
      r.slow = (mode == MODE_HOLD) && (longint'(ae) * 10 < band * 3);
      return r;
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      int v;
      case ($urandom_range(5))
         0: v = 0;
         1: v = 32'h7FFFFFFF;
         2: v = 32'h80000000;
         3: v = $urandom;
         default: begin
            v = $urandom_range(0, 32'h30000);
            if ($urandom_range(1)) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic logic [SPEED_W-1:0] pick_speed();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return SPEED_W'($urandom_range(0, 24'hFFFFFF));
         default: return SPEED_W'($urandom_range(24'h400, 24'h200000));
      endcase
   endfunction

   function automatic logic [BAND_W-1:0] pick_band();
      case ($urandom_range(4))
         0: return 16'd1;
         1: return 16'hFFFF;
         2: return BAND_W'($urandom_range(1, 65535));
         default: return BAND_W'($urandom_range(10, 2000));
      endcase
   endfunction

   function automatic logic [SPEED_W-1:0] pick_threshold();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return SPEED_W'($urandom_range(0, 24'hFFFFFF));
         default: return SPEED_W'($urandom_range(0, 4096));
      endcase
   endfunction

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
         input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GAIN_P:    cfg_gain_p = longint'(signed'(data));
         CSR_GAIN_I:    cfg_gain_i = longint'(signed'(data));
         CSR_GAIN_D:    cfg_gain_d = longint'(signed'(data));
         CSR_MAX_SPEED: cfg_max_speed = longint'(data[SPEED_W-1:0]);
         CSR_MIN_HOLD:  cfg_min_hold = longint'(data[SPEED_W-1:0]);
         CSR_HOLD_BAND: cfg_band = longint'(data[BAND_W-1:0]);
         CSR_THRESHOLD: cfg_threshold = longint'(data[SPEED_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic load_registers(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
         input logic [GAIN_W-1:0] gd, input logic [SPEED_W-1:0] top_speed,
         input logic [SPEED_W-1:0] hold_floor, input logic [BAND_W-1:0] band,
         input logic [SPEED_W-1:0] threshold);
      write_register(CSR_GAIN_P, gp);
      write_register(CSR_GAIN_I, gi);
      write_register(CSR_GAIN_D, gd);
      write_register(CSR_MAX_SPEED, CSR_DATA_W'(top_speed));
      write_register(CSR_MIN_HOLD, CSR_DATA_W'(hold_floor));
      write_register(CSR_HOLD_BAND, CSR_DATA_W'(band));
      write_register(CSR_THRESHOLD, CSR_DATA_W'(threshold));
      csr_valid <= 1'b0;
   endtask

   task automatic send_tick(input logic [MODE_W-1:0] mode, input logic [PRESS_W-1:0] target,
         input logic [PRESS_W-1:0] measured, input logic typed,
         input speed_result_type typed_result);
      speed_result_type predicted;
      if (!no_gaps && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_target_pressure <= target;
      req_measured_pressure <= measured;
      do @(posedge clock); while (!req_ready);
      predicted = advance_speed_loop(mode, target, measured);
      pending_speed_results.push_back(typed ? typed_result : predicted);
   endtask

   task automatic drain_controller();
      req_valid <= 1'b0;
      while (pending_speed_results.size() != 0) @(posedge clock);
      repeat (LATENCY_GUARD) @(posedge clock);
   endtask

   initial begin
      int seen;
      int hold;
      seen = 0;
      hold = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_requests != seen) begin
            seen = stall_requests;
            hold = STALL_CYCLES;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= no_gaps || ($urandom_range(99) >= 17);
         end
      end
   end

   always @(posedge clock) begin
      speed_result_type got;
      speed_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_speed_out, rsp_send_speed, rsp_target_rpm, rsp_slow_period};
         if (pending_speed_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("cycle %0d: unexpected transaction, speed %h send %b rpm %h slow %b",
                        cycle_count, got.speed, got.send, got.rpm, got.slow);
         end else begin
            want = pending_speed_results.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("cycle %0d: expected speed %h send %b rpm %h slow %b, got %h %b %h %b",
                           cycle_count, want.speed, want.send, want.rpm, want.slow,
                           got.speed, got.send, got.rpm, got.slow);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int                 p;
      int                 n;
      int                 row;
      int                 pick;
      int                 span;
      int                 level;
      logic [MODE_W-1:0]  mode_now;
      logic [PRESS_W-1:0] setpoint;
      logic [PRESS_W-1:0] target;
      logic [PRESS_W-1:0] measured;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= MODE_STOPPED;
      req_target_pressure <= '0;
      req_measured_pressure <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_GAIN_P;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (row == FIRST_TUNED_ROW) begin
            drain_controller();
            load_registers(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 24'hFFFFFF,
                           24'h001000, 16'd0, 24'd0);
         end
         send_tick(directed_rows[row].mode, directed_rows[row].target,
                   directed_rows[row].measured, directed_rows[row].typed,
                   directed_rows[row].want);
      end

      mode_now = MODE_PRESSURIZE;
      setpoint = 16'd20000;
      for (p = 0; p < RANDOM_PHASES; p++) begin
         drain_controller();
         case (p)
            0: load_registers(32'h0000_8000, 32'h0000_2000, 32'h0000_1000, 24'h0FA000,
                              24'h019000, 16'd200, 24'd1280);
            3: load_registers(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF,
                              24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
            4: load_registers(32'h80000000, 32'h80000000, 32'h80000000, 24'd0,
                              24'd0, 16'd1, 24'd0);
            default: load_registers(pick_gain(), pick_gain(), pick_gain(), pick_speed(),
                                    pick_speed(), pick_band(), pick_threshold());
         endcase
         no_gaps = (p == 1);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == STALL_PHASE && n == 40) stall_requests++;
            if ($urandom_range(99) < 10) begin
               pick = $urandom_range(99);
               mode_now = (pick < 45) ? MODE_PRESSURIZE :
                          (pick < 85) ? MODE_HOLD :
                          (pick < 95) ? MODE_STOPPED : MODE_OTHER;
            end
            if ($urandom_range(99) < 6) setpoint = PRESS_W'($urandom_range(0, 65535));
            target = ($urandom_range(99) < 10) ? PRESS_W'($urandom_range(0, 65535)) : setpoint;
            case ($urandom_range(9))
               0, 1: span = -1;
               2, 3, 4: span = 4000;
               default: span = 2 * ((cfg_band == 0) ? 1 : int'(cfg_band));
            endcase
            if (span < 0) begin
               measured = PRESS_W'($urandom_range(0, 65535));
            end else begin
               level = int'(setpoint)
                     + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(0, span));
               if (level < 0) level = 0;
               if (level > 65535) level = 65535;
               measured = level[PRESS_W-1:0];
            end
            send_tick(mode_now, target, measured, 1'b0, QUIET);
         end
      end

      no_gaps = 1'b0;
      drain_controller();
      if (fail_count == 0 && pending_speed_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
